>>> rtl/skst_pkg.sv
`default_nettype none
package skst_pkg;

	// fixed field widths
	localparam int KEY_W = 32;
	localparam int POS_W = 5;
	localparam int CNT_OUT_W = 5;

	// default table depth
	localparam int CAPACITY_DEF = 16;

	// operation codes
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;
	localparam logic [1:0] KIND_CLEAR  = 2'd3;

	// result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_DUP      = 2'd1;
	localparam logic [1:0] STATUS_NOTFOUND = 2'd2;
	localparam logic [1:0] STATUS_FULL     = 2'd3;

	// request beat
	typedef struct packed {
		logic [1:0]              kind;
		logic signed [KEY_W-1:0] key;
	} req_t;

	// result beat
	typedef struct packed {
		logic [1:0]           status;
		logic                 found;
		logic [POS_W-1:0]     position;
		logic [CNT_OUT_W-1:0] count;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic compare;
		logic execute;
	} cmd_t;

endpackage
`default_nettype wire

>>> rtl/skst_ctrl.sv
`default_nettype none
module skst_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	output logic               done,
	output skst_pkg::cmd_t     cmd
);
	import skst_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_EXE  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       accept;
	logic       done_q;

	// a new beat may enter while the previous one executes
	assign busy   = (state_q == ST_CMP);
	assign accept = start && !busy;

	assign cmd.load    = accept;
	assign cmd.compare = (state_q == ST_CMP);
	assign cmd.execute = (state_q == ST_EXE);
	assign done        = done_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_nxt = ST_CMP;
			end
			ST_CMP: begin
				state_nxt = ST_EXE;
			end
			ST_EXE: begin
				state_nxt = accept ? ST_CMP : ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= cmd.execute;
		end
	end

endmodule
`default_nettype wire

>>> rtl/skst_dp.sv
`default_nettype none
module skst_dp #(
	parameter int CAPACITY = skst_pkg::CAPACITY_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire skst_pkg::cmd_t cmd,
	input  wire skst_pkg::req_t req,
	output skst_pkg::rsp_t      rsp
);
	import skst_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic signed [KEY_W-1:0] cell_q [CAPACITY];
	logic [CNT_W-1:0]        cnt_q;
	logic [1:0]              kind_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CAPACITY-1:0]     lt_s1;
	logic [CAPACITY-1:0]     eq_s1;
	rsp_t                    rsp_q;
	rsp_t                    rsp_nxt;

	logic [CAPACITY-1:0] bound;
	logic [CNT_W-1:0]    rank;
	logic                hit;
	logic                full;
	logic                do_ins;
	logic                do_del;

	// capture the request beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= req.kind;
			key_q  <= req.key;
		end
	end

	// per-cell compare against the key
	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			for (int i = 0; i < CAPACITY; i++) begin
				lt_s1[i] <= (cnt_q > CNT_W'(i)) && (cell_q[i] < key_q);
				eq_s1[i] <= (cnt_q > CNT_W'(i)) && (cell_q[i] == key_q);
			end
		end
	end

	// rank from the thermometer of smaller keys
	always_comb begin
		rank = CNT_W'(CAPACITY);
		for (int i = 0; i < CAPACITY; i++) begin
			bound[i] = !lt_s1[i] && ((i == 0) ? 1'b1 : lt_s1[(i == 0) ? 0 : i - 1]);
		end
		for (int i = 0; i < CAPACITY; i++) begin
			if (bound[i]) rank = CNT_W'(i);
		end
	end

	assign hit    = |eq_s1;
	assign full   = (cnt_q == CNT_W'(CAPACITY));
	assign do_ins = cmd.execute && (kind_q == KIND_INSERT) && !hit && !full;
	assign do_del = cmd.execute && (kind_q == KIND_DELETE) && hit;

	// cells: shift up on insert, shift down on delete
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (do_ins && !lt_s1[g]) begin
				if (g == 0) begin
					cell_q[g] <= key_q;
				end else if (lt_s1[(g == 0) ? 0 : g - 1]) begin
					cell_q[g] <= key_q;
				end else begin
					cell_q[g] <= cell_q[(g == 0) ? 0 : g - 1];
				end
			end else if (do_del && !lt_s1[g] && (g < CAPACITY - 1)) begin
				cell_q[g] <= cell_q[(g < CAPACITY - 1) ? g + 1 : g];
			end
		end
	end

	// key count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.execute) begin
			if (kind_q == KIND_CLEAR) cnt_q <= '0;
			else if (do_ins)           cnt_q <= cnt_q + CNT_W'(1);
			else if (do_del)           cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// result fields for the executing beat
	always_comb begin
		rsp_nxt.status   = STATUS_OK;
		rsp_nxt.found    = hit;
		rsp_nxt.position = POS_W'(rank);
		rsp_nxt.count    = CNT_OUT_W'(cnt_q);
		case (kind_q)
			KIND_INSERT: begin
				rsp_nxt.count = CNT_OUT_W'(cnt_q + CNT_W'(do_ins));
				if (hit)       rsp_nxt.status = STATUS_DUP;
				else if (full) rsp_nxt.status = STATUS_FULL;
			end
			KIND_DELETE: begin
				rsp_nxt.count = CNT_OUT_W'(cnt_q - CNT_W'(do_del));
				if (!hit) rsp_nxt.status = STATUS_NOTFOUND;
			end
			KIND_LOOKUP: begin
				if (!hit) rsp_nxt.status = STATUS_NOTFOUND;
			end
			default: begin
				rsp_nxt.count    = '0;
				rsp_nxt.found    = 1'b0;
				rsp_nxt.position = '0;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp = rsp_q;

endmodule
`default_nettype wire

>>> rtl/sorted_key_set_table.sv
`default_nettype none
// Sorted set of up to CAPACITY distinct signed 32-bit keys. Raise start with a
// request beat (insert, delete, lookup or clear); it is taken when busy is low.
// Every request gives exactly one result beat on rsp, marked by done for one
// cycle, after the request has passed the compare and execute states; the result
// cannot be held off, so capture it when done is high. A new request may be taken
// while the previous one executes: the compare state checks the key against all
// stored cells at once, the execute state shifts the cells and updates the count.
// No clearing is needed after reset; the table starts empty.
module sorted_key_set_table #(
	parameter int CAPACITY = skst_pkg::CAPACITY_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire skst_pkg::req_t req,
	output logic                done,
	output skst_pkg::rsp_t      rsp
);
	import skst_pkg::*;

	cmd_t cmd;

	// sequencing
	skst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// key cells and result
	skst_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire

>>> rtl/skst_checker.sv
`default_nettype none
module skst_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire logic           done,
	input wire skst_pkg::rsp_t rsp
);
	import skst_pkg::*;

	// an accepted beat raises busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	// busy always falls right after it is raised
	a_busy_short: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held too long");

	// each accepted beat gives a result beat marked by done
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result missing");

	// a duplicate is by definition a key already present
	a_dup_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == STATUS_DUP) |-> rsp.found)
		else $error("duplicate without found");

endmodule

bind sorted_key_set_table skst_checker u_skst_checker (.*);
`default_nettype wire

>>> test/sorted_key_set_table_checker.sv
`timescale 1ns / 100ps
module sorted_key_set_table_checker
	import skst_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic busy,
	input  wire req_t req,
	input  wire logic done,
	input  wire rsp_t rsp,
	output int        mismatch_count,
	output int        results_due
);

	// shadow copy of the sorted table
	logic signed [KEY_W-1:0] held_keys [CAPACITY];
	int                      held_count = 0;

	// results predicted but not yet seen, oldest first
	rsp_t table_results_due [$];

	initial mismatch_count = 0;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// applies one operation to the shadow table and returns its result beat
	function automatic rsp_t table_op_outcome(input req_t op);
		rsp_t                    outcome;
		int                      rank;
		logic                    hit;
		logic signed [KEY_W-1:0] k;
		outcome = '0;
		rank = 0;
		hit = 1'b0;
		k = $signed(op.key);
		if (op.kind == KIND_CLEAR) begin
			held_count = 0;
		end else begin
			// rank is the number of held keys below the key
			while (rank < held_count && held_keys[rank] < k)
				rank++;
			hit = (rank < held_count) && (held_keys[rank] == k);
			case (op.kind)
				KIND_INSERT: begin
					if (hit) begin
						outcome.status = STATUS_DUP;
					end else if (held_count >= CAPACITY) begin
						outcome.status = STATUS_FULL;
					end else begin
						for (int i = held_count; i > rank; i--)
							held_keys[i] = held_keys[i-1];
						held_keys[rank] = k;
						held_count++;
					end
				end
				KIND_DELETE: begin
					if (hit) begin
						for (int i = rank; i + 1 < held_count; i++)
							held_keys[i] = held_keys[i+1];
						held_count--;
					end else begin
						outcome.status = STATUS_NOTFOUND;
					end
				end
				default: begin
					if (!hit)
						outcome.status = STATUS_NOTFOUND;
				end
			endcase
		end
		outcome.found = hit;
		outcome.position = rank[POS_W-1:0];
		outcome.count = held_count[CNT_OUT_W-1:0];
		return outcome;
	endfunction

	// compare result beats in order, then predict the newly taken request
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (table_results_due.size() == 0) begin
					report_mismatch($sformatf("result beat with none expected (status %0d count %0d)",
						rsp.status, rsp.count));
				end else begin
					want = table_results_due.pop_front();
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status expected %0d got %0d",
							want.status, rsp.status));
					if (rsp.found !== want.found)
						report_mismatch($sformatf("found expected %0d got %0d",
							want.found, rsp.found));
					if (rsp.position !== want.position)
						report_mismatch($sformatf("position expected %0d got %0d",
							want.position, rsp.position));
					if (rsp.count !== want.count)
						report_mismatch($sformatf("count expected %0d got %0d",
							want.count, rsp.count));
				end
			end
			if (start && !busy)
				table_results_due.push_back(table_op_outcome(req));
		end
		results_due = table_results_due.size();
	end

	initial results_due = 0;

endmodule

>>> test/sorted_key_set_table_tb.sv
`timescale 1ns / 100ps
module sorted_key_set_table_tb;
	import skst_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int POOL_SIZE = 24;
	localparam int RANDOM_OPS = 850;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t rsp;
	int   mismatch_count;
	int   results_due;
	int   quiet_cycles = 0;
	int   burst_left = 0;

	// small key pool so that hits, duplicates and a full table are common
	logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

	always #6 clk = ~clk;

	sorted_key_set_table #(
		.CAPACITY(CAPACITY_DEF)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	sorted_key_set_table_checker #(
		.CAPACITY(CAPACITY_DEF)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req           (req),
		.done          (done),
		.rsp           (rsp),
		.mismatch_count(mismatch_count),
		.results_due   (results_due)
	);

	// watchdog on cycles with no beat in either direction
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// present one request beat, hold it until taken, then maybe pause
	task automatic send_op(input logic [1:0] kind, input logic signed [KEY_W-1:0] key);
		start <= 1'b1;
		req <= '{kind: kind, key: key};
		do @(posedge clk); while (busy);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			// some bursts are long, giving stretches with no idling
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 6);
		end
	endtask

	task automatic refill_key_pool();
		key_pool[0] = 32'sh8000_0000;
		key_pool[1] = 32'sh7fff_ffff;
		key_pool[2] = 32'sh0000_0000;
		key_pool[3] = 32'shffff_ffff;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = ($urandom_range(0, 1) == 0) ? $urandom
				: $signed($urandom_range(0, 200)) - 100;
	endtask

	function automatic logic signed [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return key_pool[$urandom_range(0, POOL_SIZE - 1)];
	endfunction

	// weighted operation choice; the weights shift from phase to phase
	function automatic logic [1:0] pick_kind(input int ins_w, input int del_w, input int look_w);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < ins_w)
			return KIND_INSERT;
		if (roll < ins_w + del_w)
			return KIND_DELETE;
		if (roll < ins_w + del_w + look_w)
			return KIND_LOOKUP;
		return KIND_CLEAR;
	endfunction

	initial begin
		int ins_w;
		int del_w;
		int look_w;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, duplicates, misses, full table, clear
		send_op(KIND_CLEAR, 32'sh1234_5678);
		send_op(KIND_INSERT, 32'sh8000_0000);
		send_op(KIND_INSERT, 32'sh7fff_ffff);
		send_op(KIND_INSERT, 32'sh0000_0000);
		send_op(KIND_INSERT, 32'shffff_ffff);
		send_op(KIND_INSERT, 32'sh0000_0000);
		send_op(KIND_LOOKUP, 32'sh7fff_ffff);
		send_op(KIND_LOOKUP, 32'sh0000_0005);
		send_op(KIND_DELETE, 32'sh0000_0007);
		send_op(KIND_DELETE, 32'sh8000_0000);
		for (int i = 0; i < 13; i++)
			send_op(KIND_INSERT, (i % 2) ? i * 1000 + 7 : -(i * 1000 + 7));
		send_op(KIND_INSERT, 32'sh0000_0005);
		send_op(KIND_LOOKUP, 32'shffff_ffff);
		send_op(KIND_DELETE, 32'sh7fff_ffff);
		send_op(KIND_CLEAR, 32'shdead_beef);

		// random phases: filling, draining and mixed traffic
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n % 60 == 0) begin
				refill_key_pool();
				case ($urandom_range(0, 2))
					0: begin ins_w = 70; del_w = 10; look_w = 18; end
					1: begin ins_w = 25; del_w = 50; look_w = 23; end
					default: begin ins_w = 40; del_w = 28; look_w = 29; end
				endcase
			end
			send_op(pick_kind(ins_w, del_w, look_w), pick_key());
		end
		start <= 1'b0;

		wait (results_due == 0);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
